/* hw/rtl/sroc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sroc_pkg
// Shared types and constants for the segment / rectangle obstacle checker.
// ----------------------------------------------------------------------------
package sroc_pkg;

    localparam int COORD_W   = 32;
    localparam int TBL_DEPTH = 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int TOL_W     = 16;
    localparam int ENTRY_W   = 4 * COORD_W;
    localparam int PROD_W    = 67;   // 34b x 33b signed

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_POINT   = 2'd1;
    localparam logic [1:0] OP_SEGMENT = 2'd2;

    localparam logic [1:0] OUT_WRITTEN  = 2'd0;
    localparam logic [1:0] OUT_CLEAR    = 2'd1;
    localparam logic [1:0] OUT_ENDPOINT = 2'd2;
    localparam logic [1:0] OUT_CROSS    = 2'd3;

    localparam logic REG_OBS_COUNT = 1'b0;
    localparam logic REG_ZERO_TOL  = 1'b1;

    typedef struct packed {
        logic [1:0]                 op;
        logic [IDX_W-1:0]           entry_index;
        logic signed [COORD_W-1:0]  x_first;
        logic signed [COORD_W-1:0]  y_first;
        logic signed [COORD_W-1:0]  x_second;
        logic signed [COORD_W-1:0]  y_second;
    } t_in;

    typedef struct packed {
        logic [1:0]       outcome;
        logic [IDX_W-1:0] blocker_index;
    } t_out;

    typedef struct packed {
        logic             load_in;
        logic             setup;
        logic             ram_we;
        logic             mul_en;
        logic [1:0]       side;
        logic [IDX_W-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       vert;
        logic       horz;
        logic       ep_hit;
        logic       ax_hit;
        logic       side_hit;
    } t_stat;

endpackage

/* hw/rtl/sroc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sroc_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sroc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/sroc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sroc_dp
// Datapath: item registers, obstacle table, endpoint / axis / side tests.
// ----------------------------------------------------------------------------
module sroc_dp import sroc_pkg::*; (
    input  logic             i_clk,
    input  t_in              i_in_data,
    input  logic [TOL_W-1:0] i_zero_tol,
    input  t_cmd             i_cmd,
    output t_stat            o_stat
);

    logic [1:0]                r_op;
    logic [IDX_W-1:0]          r_eidx;
    logic signed [COORD_W-1:0] r_x1, r_y1, r_x2, r_y2;
    logic                      r_vert, r_horz;
    logic signed [COORD_W+1:0] r_ax, r_ox, r_ay, r_oy;
    logic signed [PROD_W-1:0]  r_m, r_pl, r_ph;
    logic                      r_cin;

    logic [ENTRY_W-1:0]        w_rdata;
    logic signed [COORD_W-1:0] w_xmin, w_ymin, w_xmax, w_ymax;

    logic signed [COORD_W:0]   w_dx, w_dy;
    logic [COORD_W:0]          w_mdx, w_mdy;
    logic                      w_nzx, w_nzy;

    logic signed [COORD_W-1:0] w_c, w_s0, w_e0, w_lo, w_hi, w_s1, w_mn, w_mx;
    logic signed [COORD_W+1:0] w_a, w_o;
    logic signed [COORD_W:0]   w_cd, w_ld, w_hd;
    logic signed [PROD_W-1:0]  w_m, w_pl, w_ph;

    logic w_in1, w_in2, w_vhit, w_hhit;

    sroc_ram #(.WIDTH(ENTRY_W), .DEPTH(TBL_DEPTH)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_waddr (r_eidx),
        .i_wdata ({r_y2, r_x2, r_y1, r_x1}),
        .i_raddr (i_cmd.addr),
        .o_rdata (w_rdata)
    );

    assign w_xmin = w_rdata[COORD_W-1:0];
    assign w_ymin = w_rdata[2*COORD_W-1:COORD_W];
    assign w_xmax = w_rdata[3*COORD_W-1:2*COORD_W];
    assign w_ymax = w_rdata[4*COORD_W-1:3*COORD_W];

    // line classification
    assign w_dx  = {r_x2[COORD_W-1], r_x2} - {r_x1[COORD_W-1], r_x1};
    assign w_dy  = {r_y2[COORD_W-1], r_y2} - {r_y1[COORD_W-1], r_y1};
    assign w_mdx = w_dx[COORD_W] ? (COORD_W+1)'(0) - w_dx : w_dx;
    assign w_mdy = w_dy[COORD_W] ? (COORD_W+1)'(0) - w_dy : w_dy;
    assign w_nzx = (w_dx == '0) || (w_mdx < {{(COORD_W+1-TOL_W){1'b0}}, i_zero_tol});
    assign w_nzy = (w_dy == '0) || (w_mdy < {{(COORD_W+1-TOL_W){1'b0}}, i_zero_tol});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_in_data.op;
            r_eidx <= i_in_data.entry_index;
            r_x1   <= i_in_data.x_first;
            r_y1   <= i_in_data.y_first;
            r_x2   <= i_in_data.x_second;
            r_y2   <= i_in_data.y_second;
        end
        if (i_cmd.setup) begin
            r_vert <= w_nzx;
            r_horz <= !w_nzx && w_nzy;
            r_ax   <= $signed({1'b0, w_mdx});
            r_ay   <= $signed({1'b0, w_mdy});
            // direction flipped so the axis delta is non-negative
            r_ox   <= w_dx[COORD_W] ? -$signed({w_dy[COORD_W], w_dy})
                                    :  $signed({w_dy[COORD_W], w_dy});
            r_oy   <= w_dy[COORD_W] ? -$signed({w_dx[COORD_W], w_dx})
                                    :  $signed({w_dx[COORD_W], w_dx});
        end
        if (i_cmd.mul_en) begin
            r_m   <= w_m;
            r_pl  <= w_pl;
            r_ph  <= w_ph;
            r_cin <= (w_c >= w_mn) && (w_c <= w_mx);
        end
    end

    // endpoint containment, bounds inclusive
    assign w_in1 = (r_x1 >= w_xmin) && (r_x1 <= w_xmax) && (r_y1 >= w_ymin) && (r_y1 <= w_ymax);
    assign w_in2 = (r_x2 >= w_xmin) && (r_x2 <= w_xmax) && (r_y2 >= w_ymin) && (r_y2 <= w_ymax);

    assign w_vhit = (r_x2 >= w_xmin) && (r_x2 <= w_xmax) &&
                    (((r_y1 >= w_ymin) && (r_y1 <= w_ymax)) ||
                     ((r_y2 >= w_ymin) && (r_y2 <= w_ymax)) ||
                     ((r_y1 <= w_ymin) && (r_y2 >= w_ymax)) ||
                     ((r_y2 <= w_ymin) && (r_y1 >= w_ymax)));
    assign w_hhit = (r_y2 >= w_ymin) && (r_y2 <= w_ymax) &&
                    (((r_x1 >= w_xmin) && (r_x1 <= w_xmax)) ||
                     ((r_x2 >= w_xmin) && (r_x2 <= w_xmax)) ||
                     ((r_x1 <= w_xmin) && (r_x2 >= w_xmax)) ||
                     ((r_x2 <= w_xmin) && (r_x1 >= w_xmax)));

    // side operands: sides 0/1 are x = xmin/xmax, sides 2/3 are y = ymin/ymax
    always_comb begin
        if (!i_cmd.side[1]) begin
            w_c  = i_cmd.side[0] ? w_xmax : w_xmin;
            w_s0 = r_x1;
            w_e0 = r_x2;
            w_lo = w_ymin;
            w_hi = w_ymax;
            w_s1 = r_y1;
            w_a  = r_ax;
            w_o  = r_ox;
        end else begin
            w_c  = i_cmd.side[0] ? w_ymax : w_ymin;
            w_s0 = r_y1;
            w_e0 = r_y2;
            w_lo = w_xmin;
            w_hi = w_xmax;
            w_s1 = r_x1;
            w_a  = r_ay;
            w_o  = r_oy;
        end
    end

    assign w_mn = (w_s0 < w_e0) ? w_s0 : w_e0;
    assign w_mx = (w_s0 < w_e0) ? w_e0 : w_s0;
    assign w_cd = {w_c[COORD_W-1], w_c}   - {w_s0[COORD_W-1], w_s0};
    assign w_ld = {w_lo[COORD_W-1], w_lo} - {w_s1[COORD_W-1], w_s1};
    assign w_hd = {w_hi[COORD_W-1], w_hi} - {w_s1[COORD_W-1], w_s1};
    assign w_m  = w_o * w_cd;
    assign w_pl = w_ld * w_a;
    assign w_ph = w_hd * w_a;

    assign o_stat.op       = r_op;
    assign o_stat.vert     = r_vert;
    assign o_stat.horz     = r_horz;
    assign o_stat.ep_hit   = w_in1 || ((r_op == OP_SEGMENT) && w_in2);
    assign o_stat.ax_hit   = r_vert ? w_vhit : w_hhit;
    assign o_stat.side_hit = (r_pl <= r_m) && (r_m <= r_ph) && r_cin;

endmodule

/* hw/rtl/sroc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sroc_ctrl
// Sequencer: decodes an item, walks the table and owns the result register.
// ----------------------------------------------------------------------------
module sroc_ctrl import sroc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out_data,
    input  logic [CNT_W-1:0] i_obs_n,
    input  t_stat            i_stat,
    output t_cmd             o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DECODE   = 9'b000000010,
        S_EP_RD    = 9'b000000100,
        S_EP_CHK   = 9'b000001000,
        S_SG_RD    = 9'b000010000,
        S_SG_CHK   = 9'b000100000,
        S_SIDE_MUL = 9'b001000000,
        S_SIDE_CMP = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [1:0]       r_side, n_side;
    t_out             r_res, n_res;
    logic             r_out_valid, n_out_valid;
    t_out             r_out_data;
    logic             w_load_out;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_side     = r_side;
        n_res      = r_res;
        w_load_out = 1'b0;
        o_cmd         = '0;
        o_cmd.addr    = r_idx[IDX_W-1:0];
        o_cmd.side    = r_side;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_idx         = '0;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.setup = 1'b1;
                n_res       = '{outcome: OUT_WRITTEN, blocker_index: '0};
                case (i_stat.op)
                    OP_WRITE: begin
                        o_cmd.ram_we = 1'b1;
                        n_state      = S_DONE;
                    end
                    OP_POINT, OP_SEGMENT: n_state = S_EP_RD;
                    default:              n_state = S_DONE;
                endcase
            end
            S_EP_RD: begin
                if (r_idx == i_obs_n) begin
                    if (i_stat.op == OP_POINT) begin
                        n_res   = '{outcome: OUT_CLEAR, blocker_index: '0};
                        n_state = S_DONE;
                    end else begin
                        n_idx   = '0;
                        n_state = S_SG_RD;
                    end
                end else begin
                    n_state = S_EP_CHK;
                end
            end
            S_EP_CHK: begin
                if (i_stat.ep_hit) begin
                    n_res   = '{outcome: OUT_ENDPOINT, blocker_index: r_idx[IDX_W-1:0]};
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_EP_RD;
                end
            end
            S_SG_RD: begin
                if (r_idx == i_obs_n) begin
                    n_res   = '{outcome: OUT_CLEAR, blocker_index: '0};
                    n_state = S_DONE;
                end else if (i_stat.vert || i_stat.horz) begin
                    n_state = S_SG_CHK;
                end else begin
                    n_side  = 2'd0;
                    n_state = S_SIDE_MUL;
                end
            end
            S_SG_CHK: begin
                if (i_stat.ax_hit) begin
                    n_res   = '{outcome: OUT_CROSS, blocker_index: r_idx[IDX_W-1:0]};
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SG_RD;
                end
            end
            S_SIDE_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_SIDE_CMP;
            end
            S_SIDE_CMP: begin
                if (i_stat.side_hit) begin
                    n_res   = '{outcome: OUT_CROSS, blocker_index: r_idx[IDX_W-1:0]};
                    n_state = S_DONE;
                end else if (r_side == 2'd3) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SG_RD;
                end else begin
                    n_side  = r_side + 2'd1;
                    n_state = S_SIDE_MUL;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = w_load_out || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_side      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_side      <= n_side;
        end
        r_res <= n_res;
        if (w_load_out) begin
            r_out_data <= r_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* hw/rtl/segment_rect_obstacle_check_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_rect_obstacle_check_top
// Rectangle obstacle table with point and segment collision queries.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): one beat is one item; op selects
// a table write, a point test or a segment test. Output channel
// (o_out_valid / i_out_stall): one result beat per item.
// Items are handled one at a time; a query scans the table entries in order,
// up to the saturated obstacle count, one table read per entry:
//   write or unused op : decode (writing the table on a write), then done
//   point test         : read and check each entry until an endpoint hit
//   segment test       : endpoint pass as above, then per entry a read and
//                        a check for near-axis lines, or four sides for
//                        general lines (multiply then compare each)
// A finished result sits in an output register, so the next item is taken
// while the receiver stalls; a second result then waits in the sequencer.
// Reset clears the config registers, the output valid and the sequencer;
// table contents stay undefined until written. Config via APB: 0x0
// obstacle count, 0x4 zero tolerance.
// ----------------------------------------------------------------------------
module segment_rect_obstacle_check_top import sroc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CNT_W-1:0] r_obs_cnt;
    logic [TOL_W-1:0] r_zero_tol;
    logic [CNT_W-1:0] w_obs_n;
    logic             w_wr;
    t_cmd             w_cmd;
    t_stat            w_stat;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs_cnt  <= '0;
            r_zero_tol <= '0;
        end else if (w_wr) begin
            if (paddr[2] == REG_OBS_COUNT) begin
                r_obs_cnt <= pwdata[CNT_W-1:0];
            end else begin
                r_zero_tol <= pwdata[TOL_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_ZERO_TOL) ? {{(32-TOL_W){1'b0}}, r_zero_tol}
                                               : {{(32-CNT_W){1'b0}}, r_obs_cnt};

    assign w_obs_n = (r_obs_cnt > CNT_W'(TBL_DEPTH)) ? CNT_W'(TBL_DEPTH) : r_obs_cnt;

    sroc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_obs_n     (w_obs_n),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    sroc_dp u_dp (
        .i_clk      (i_clk),
        .i_in_data  (i_in_data),
        .i_zero_tol (r_zero_tol),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat)
    );

    a_blk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.outcome == OUT_WRITTEN || o_out_data.outcome == OUT_CLEAR)
        |-> o_out_data.blocker_index == '0)
        else $error("blocker index set on a clear or write result");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after an accepted item");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in work");

    a_no_accept_and_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ram_we |-> o_in_stall)
        else $error("table written while idle");

endmodule
